[rtl/core/jsu_pkg.sv]
// Types and constants shared by the JSON string unescape unit.
`default_nettype none
package jsu_pkg;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CODE_BS      = 8'h08;
   localparam logic [7:0] CODE_FF      = 8'h0C;
   localparam logic [7:0] CODE_LF      = 8'h0A;
   localparam logic [7:0] CODE_CR      = 8'h0D;
   localparam logic [7:0] CODE_TAB     = 8'h09;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_IN   = 2'd1,
      PH_ESC  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_NOOPEN  = 2'd2,
      KIND_NOCLOSE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] out_char;
      kind_type   kind;
      logic       last;
   } result_type;

   typedef struct packed {
      phase_type  phase_next;
      logic [1:0] count;
      result_type beat0;
      result_type beat1;
   } dec_type;

endpackage
`default_nettype wire

[rtl/core/jsu_if.sv]
// Handshake channels for raw text bytes and decoded result beats.
`default_nettype none
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface jsu_rsp_if
   import jsu_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   kind_type   kind;
   logic       last;

   modport source (output valid, output out_char, output kind, output last, input ready);
   modport sink (input valid, input out_char, input kind, input last, output ready);
endinterface
`default_nettype wire

[rtl/core/jsu_decode.sv]
// Phase update and escape decode for one text beat.
`default_nettype none
module jsu_decode
   import jsu_pkg::*;
(
   input  phase_type  phase,
   input  logic [7:0] in_byte,
   input  logic       stream_end,
   output dec_type    dec
);

   logic       is_ws;
   logic       known;
   logic [7:0] esc_value;

   assign is_ws = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));

   always_comb begin
      known = 1'b1;
      unique case (in_byte)
         CH_QUOTE:     esc_value = CH_QUOTE;
         CH_BACKSLASH: esc_value = CH_BACKSLASH;
         CH_SLASH:     esc_value = CH_SLASH;
         CH_B:         esc_value = CODE_BS;
         CH_F:         esc_value = CODE_FF;
         CH_N:         esc_value = CODE_LF;
         CH_R:         esc_value = CODE_CR;
         CH_T:         esc_value = CODE_TAB;
         default: begin
            esc_value = in_byte;
            known     = 1'b0;
         end
      endcase
   end

   always_comb begin
      dec.phase_next = phase;
      dec.count      = 2'd0;
      dec.beat0      = '{out_char: 8'h00, kind: KIND_BYTE, last: 1'b1};
      dec.beat1      = '{out_char: 8'h00, kind: KIND_BYTE, last: 1'b1};
      unique case (phase)
         PH_IN: begin
            priority if (stream_end) begin
               dec.count      = 2'd1;
               dec.beat0.kind = KIND_NOCLOSE;
               dec.phase_next = PH_WAIT;
            end else if (in_byte == CH_QUOTE) begin
               dec.count      = 2'd1;
               dec.beat0.kind = KIND_DONE;
               dec.phase_next = PH_WAIT;
            end else if (in_byte == CH_BACKSLASH) begin
               dec.phase_next = PH_ESC;
            end else begin
               dec.count          = 2'd1;
               dec.beat0.out_char = in_byte;
            end
         end
         PH_ESC: begin
            if (stream_end) begin
               dec.count          = 2'd2;
               dec.beat0.out_char = CH_BACKSLASH;
               dec.beat0.last     = 1'b0;
               dec.beat1.kind     = KIND_NOCLOSE;
               dec.phase_next     = PH_WAIT;
            end else if (known) begin
               dec.count          = 2'd1;
               dec.beat0.out_char = esc_value;
               dec.phase_next     = PH_IN;
            end else begin
               dec.count          = 2'd2;
               dec.beat0.out_char = CH_BACKSLASH;
               dec.beat0.last     = 1'b0;
               dec.beat1.out_char = in_byte;
               dec.phase_next     = PH_IN;
            end
         end
         default: begin
            dec.phase_next = PH_WAIT;
            priority if (stream_end) begin
               dec.count      = 2'd1;
               dec.beat0.kind = KIND_NOOPEN;
            end else if (in_byte == CH_QUOTE) begin
               dec.phase_next = PH_IN;
            end else if (!is_ws) begin
               dec.count      = 2'd1;
               dec.beat0.kind = KIND_NOOPEN;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/json_string_unescape_unit.sv]
// Top level of the streaming JSON string unescape unit.
// One text beat is accepted per cycle while the four-entry result queue has
// room for two beats; its results are registered in the queue before they
// reach rsp_bus. While the sink keeps rsp ready high, the result port moves
// one beat per cycle, so an input that yields two results (a pending
// backslash at stream end, an unknown escape) takes two output beats, and
// the input sustains one beat per cycle while each yields at most one result.
`default_nettype none
module json_string_unescape_unit
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   jsu_req_if.sink     req_bus,
   jsu_rsp_if.source   rsp_bus
);

   localparam int unsigned QDEPTH = 4;

   phase_type   phase_ff, phase_in;
   dec_type     dec;
   result_type  slot_ff [QDEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   jsu_decode u_decode (
      .phase      (phase_ff),
      .in_byte    (req_bus.in_byte),
      .stream_end (req_bus.stream_end),
      .dec        (dec)
   );

   assign req_bus.ready    = (count_ff <= 3'd2);
   assign push             = req_bus.valid && req_bus.ready;
   assign pop              = rsp_bus.valid && rsp_bus.ready;

   assign rsp_bus.valid    = (count_ff != 3'd0);
   assign rsp_bus.out_char = slot_ff[rd_ptr_ff].out_char;
   assign rsp_bus.kind     = slot_ff[rd_ptr_ff].kind;
   assign rsp_bus.last     = slot_ff[rd_ptr_ff].last;

   always_comb begin
      phase_in  = push ? dec.phase_next : phase_ff;
      wr_ptr_in = push ? (wr_ptr_ff + dec.count) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 2'd1) : rd_ptr_ff;
      count_in  = count_ff + (push ? {1'b0, dec.count} : 3'd0) - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         phase_ff  <= phase_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (dec.count != 2'd0)) begin
         slot_ff[wr_ptr_ff] <= dec.beat0;
      end
      if (push && (dec.count == 2'd2)) begin
         slot_ff[wr_ptr_ff + 2'd1] <= dec.beat1;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overfilled");

   a_phase_legal : assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("phase left its legal codes");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind != KIND_BYTE) |-> rsp_bus.last && (rsp_bus.out_char == 8'h00))
      else $error("status beat without last or with data");

   a_esc_yields : assert property (@(posedge clock) disable iff (reset)
      push && (phase_ff == PH_ESC) |-> (dec.count != 2'd0) && (dec.phase_next != PH_ESC))
      else $error("escape beat produced no result");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      push && (dec.count == 2'd2) |-> !dec.beat0.last && dec.beat1.last)
      else $error("two-result beat marked last out of order");

endmodule
`default_nettype wire

[tb/sv/json_string_unescape_unit_test.sv]
// Self-checking testbench for the JSON string unescape unit under random handshake stalls.
`default_nettype none
module json_string_unescape_unit_test
   import jsu_pkg::*;
   ;

   localparam logic [8:0]  TEXT_END      = 9'h100;
   localparam logic [7:0]  CH_VT         = 8'h0B;
   localparam int unsigned TEXT_TOTAL    = 1375;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned SETTLE_CYCLES = 16;

   class unescape_scoreboard;
      phase_type   text_phase;
      result_type  pending_results[$];
      int unsigned mismatches;

      function new();
         text_phase = PH_WAIT;
         mismatches = 0;
      endfunction

      function void queue_result(logic [7:0] ch, kind_type k);
         result_type r;
         r.out_char = ch;
         r.kind     = k;
         r.last     = 1'b0;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void note_text_beat(logic [7:0] b, logic at_end);
         int unsigned queued;
         logic [7:0]  code;
         logic        known;
         queued = pending_results.size();
         case (text_phase)
            PH_IN: begin
               if (at_end) begin
                  queue_result(8'h00, KIND_NOCLOSE);
                  text_phase = PH_WAIT;
               end else if (b == CH_QUOTE) begin
                  queue_result(8'h00, KIND_DONE);
                  text_phase = PH_WAIT;
               end else if (b == CH_BACKSLASH) begin
                  text_phase = PH_ESC;
               end else begin
                  queue_result(b, KIND_BYTE);
               end
            end
            PH_ESC: begin
               if (at_end) begin
                  queue_result(CH_BACKSLASH, KIND_BYTE);
                  queue_result(8'h00, KIND_NOCLOSE);
                  text_phase = PH_WAIT;
               end else begin
                  known = 1'b1;
                  case (b)
                     CH_QUOTE, CH_BACKSLASH, CH_SLASH: code = b;
                     CH_B: code = CODE_BS;
                     CH_F: code = CODE_FF;
                     CH_N: code = CODE_LF;
                     CH_R: code = CODE_CR;
                     CH_T: code = CODE_TAB;
                     default: begin
                        known = 1'b0;
                        code  = b;
                     end
                  endcase
                  if (!known) queue_result(CH_BACKSLASH, KIND_BYTE);
                  queue_result(code, KIND_BYTE);
                  text_phase = PH_IN;
               end
            end
            default: begin
               text_phase = PH_WAIT;
               if (at_end) begin
                  queue_result(8'h00, KIND_NOOPEN);
               end else if (b == CH_QUOTE) begin
                  text_phase = PH_IN;
               end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                  queue_result(8'h00, KIND_NOOPEN);
               end
            end
         endcase
         if (pending_results.size() > queued)
            pending_results[pending_results.size() - 1].last = 1'b1;
      endfunction

      function void check_result_beat(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: stray result beat out_char=%h kind=%0d last=%b",
                     $time, got.out_char, got.kind, got.last);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.out_char !== want.out_char) begin
            $display("%0t: out_char expected %h actual %h", $time, want.out_char, got.out_char);
            mismatches++;
         end
         if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescape_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   unescape_scoreboard tracker = new();

   int unsigned text_sent  = 0;
   int unsigned burst_left = 0;
   bit          text_on    = 1'b0;
   int unsigned sink_cycle = 0;
   int unsigned sink_mode  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin : result_sink
      result_type got;
      logic       ready_next;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.out_char = rsp_bus.out_char;
            got.kind     = rsp_bus.kind;
            got.last     = rsp_bus.last;
            tracker.check_result_beat(got);
         end
         if (sink_cycle % 48 == 0) sink_mode = $urandom_range(0, 3);
         case (sink_mode)
            0: ready_next = 1'b1;
            1: ready_next = (sink_cycle % 3) != 0;
            2: ready_next = 1'($urandom_range(0, 1));
            default: ready_next = (sink_cycle % 4) == 0;
         endcase
         sink_cycle++;
         rsp_bus.ready <= ready_next;
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_text(input logic [8:0] beat);
      logic [7:0]  data;
      int unsigned gap;
      data = beat[8] ? 8'($urandom_range(0, 255)) : beat[7:0];
      req_bus.valid      <= 1'b1;
      req_bus.in_byte    <= data;
      req_bus.stream_end <= beat[8];
      text_on = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_text_beat(data, beat[8]);
      text_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            text_on = 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
   endtask

   task automatic drain_results();
      if (text_on) begin
         req_bus.valid <= 1'b0;
         text_on = 1'b0;
      end
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 5))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CODE_LF;
         3: return CH_VT;
         4: return CODE_FF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_escape();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BACKSLASH;
         2: return CH_SLASH;
         3: return CH_B;
         4: return CH_F;
         5: return CH_N;
         6: return CH_R;
         default: return CH_T;
      endcase
   endfunction

   task automatic send_string();
      int unsigned lead;
      int unsigned body_len;
      int unsigned pick;
      logic [7:0]  plain;
      lead = $urandom_range(0, 3);
      repeat (lead) push_text({1'b0, pick_space()});
      push_text({1'b0, CH_QUOTE});
      body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      repeat (body_len) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            plain = 8'($urandom_range(0, 255));
            if (plain == CH_QUOTE || plain == CH_BACKSLASH) plain = plain ^ 8'h01;
            push_text({1'b0, plain});
         end else if (pick < 9) begin
            push_text({1'b0, CH_BACKSLASH});
            push_text({1'b0, pick_escape()});
         end else begin
            push_text({1'b0, CH_BACKSLASH});
            push_text({1'b0, 8'($urandom_range(0, 255))});
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         push_text({1'b0, CH_QUOTE});
      end else if (pick < 9) begin
         push_text(TEXT_END);
      end else begin
         push_text({1'b0, CH_BACKSLASH});
         push_text(TEXT_END);
      end
   endtask

   task automatic send_noise();
      int unsigned count;
      count = $urandom_range(1, 6);
      repeat (count) begin
         if ($urandom_range(0, 15) == 0)
            push_text(TEXT_END);
         else
            push_text({1'b0, 8'($urandom_range(0, 255))});
      end
   endtask

   initial begin : stimulus
      logic [8:0] opening_text [25];
      opening_text = '{
         {1'b0, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, CH_VT}, {1'b0, 8'hFF}, {1'b0, 8'h00},
         TEXT_END, {1'b0, CH_QUOTE}, {1'b0, 8'h00}, {1'b0, 8'hFF},
         {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_B},
         {1'b0, CH_BACKSLASH}, {1'b0, 8'h78}, {1'b0, CH_QUOTE},
         {1'b0, CH_QUOTE}, {1'b0, CH_BACKSLASH}, TEXT_END,
         {1'b0, CH_QUOTE}, {1'b0, 8'h41}, TEXT_END,
         {1'b0, CODE_LF}, {1'b0, CODE_FF}, {1'b0, CH_CR}
      };
      req_bus.valid      <= 1'b0;
      req_bus.in_byte    <= 8'h00;
      req_bus.stream_end <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_text[i]) push_text(opening_text[i]);
      drain_results();

      while (text_sent < TEXT_TOTAL) begin
         if ($urandom_range(0, 9) < 7)
            send_string();
         else
            send_noise();
         if ($urandom_range(0, 24) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_decode.sv
rtl/core/json_string_unescape_unit.sv
tb/sv/json_string_unescape_unit_test.sv
